[sv/rrol_pkg.sv]
// Shared types, constants and pointer helpers for the record ring offset lookup.
// No dependencies; imported by every module of the block.
package rrol_pkg;

  localparam int DEPTH  = 10;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int HDL_W  = 32;
  localparam int LEN_W  = 12;
  localparam int POS_W  = 16;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 88;
  localparam int M_TUSER_W = 2;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic             hit;   // offset lies inside this record
    logic [POS_W-1:0] rest;  // offset less this record's length
  } walk_res_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) r = '0;
    else                        r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic cnt_t stored_count(input ptr_t wr, input ptr_t rd, input logic full);
    cnt_t r;
    if (full)          r = cnt_t'(DEPTH);
    else if (wr >= rd) r = cnt_t'(wr) - cnt_t'(rd);
    else               r = cnt_t'(DEPTH) - cnt_t'(rd) + cnt_t'(wr);
    return r;
  endfunction

endpackage

[sv/rrol_store.sv]
// Record store: DEPTH entries of handle and length, one write and one read port.
// Read data is registered. Depends on rrol_pkg.
module rrol_store import rrol_pkg::*; (
  input  logic   clk_i,
  input  logic   we_i,
  input  ptr_t   waddr_i,
  input  entry_t wdata_i,
  input  ptr_t   raddr_i,
  output entry_t rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rrol_walk.sv]
// Compare-subtract unit of the find walk: one record per use.
// Depends on rrol_pkg.
module rrol_walk import rrol_pkg::*; (
  input  logic [POS_W-1:0] pos_i,
  input  logic [LEN_W-1:0] len_i,
  output walk_res_t        res_o
);

  logic [POS_W:0] diff;

  // a borrow means pos < len; a zero length never borrows, so it is skipped
  assign diff       = {1'b0, pos_i} - {{(POS_W + 1 - LEN_W){1'b0}}, len_i};
  assign res_o.hit  = diff[POS_W];
  assign res_o.rest = diff[POS_W-1:0];

endmodule

[sv/record_ring_offset_lookup_core.sv]
// Top level: sequencer, pointers and result register of the record ring lookup.
// Depends on rrol_pkg, rrol_store and rrol_walk.
//
//  port group | dir | tdata (low bit up)                         | tuser (low bit up)
//  s_axis     | in  | record_handle, record_length, byte_position | func
//  m_axis     | out | hit_handle, hit_length, offset_in_record,   | found, displaced_valid
//             |     | displaced_handle                            |
//
// An add reads the oldest entry on the accept beat, then writes the record, then loads the result.
// A find walks the stored records oldest first, visiting one stored record per cycle
// through the single read port and the shared compare-subtract unit, stopping at a hit or after the last record.
// The input is ready only while the sequencer is idle; one result register sits in
// front of m_axis, so a new item is taken while a result waits, and a finished item
// holds in its result state until that register is free.
// Reset clears the pointers and full flag; the record store itself is not cleared.
module record_ring_offset_lookup_core import rrol_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // record_handle, record_length, byte_position
  input  logic                 s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // hit_handle, hit_length, offset_in_record,
                                              // displaced_handle
  output logic [M_TUSER_W-1:0] m_axis_tuser   // found, displaced_valid
);

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_WALK, S_EMIT} state_e;

  state_e           state_q;
  ptr_t             wr_ptr_q, rd_ptr_q, idx_q;
  logic             full_q;
  cnt_t             cnt_q;
  logic [POS_W-1:0] pos_q;
  logic [HDL_W-1:0] in_handle_q;
  logic [LEN_W-1:0] in_length_q;

  logic             res_found_q, res_disp_valid_q;
  logic [HDL_W-1:0] res_hit_handle_q, res_disp_handle_q;
  logic [LEN_W-1:0] res_hit_length_q, res_offset_q;

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;

  logic      store_we;
  entry_t    store_wdata, store_rdata;
  ptr_t      store_raddr, wr_next;
  walk_res_t walk_res;
  logic      s_beat, out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign wr_next       = ptr_next(wr_ptr_q);

  assign store_we           = (state_q == S_ADD);
  assign store_wdata.handle = in_handle_q;
  assign store_wdata.length = in_length_q;
  // walk reads run one record ahead; otherwise keep the oldest entry on the read port
  assign store_raddr = (state_q == S_WALK) ? ptr_next(idx_q) : rd_ptr_q;

  rrol_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (store_wdata),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  rrol_walk u_walk (
    .pos_i (pos_q),
    .len_i (store_rdata.length),
    .res_o (walk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      wr_ptr_q          <= '0;
      rd_ptr_q          <= '0;
      idx_q             <= '0;
      full_q            <= 1'b0;
      cnt_q             <= '0;
      pos_q             <= '0;
      in_handle_q       <= '0;
      in_length_q       <= '0;
      res_found_q       <= 1'b0;
      res_disp_valid_q  <= 1'b0;
      res_hit_handle_q  <= '0;
      res_disp_handle_q <= '0;
      res_hit_length_q  <= '0;
      res_offset_q      <= '0;
      m_valid_q         <= 1'b0;
      m_tdata_q         <= '0;
      m_tuser_q         <= '0;
    end else begin
      // the result state reloads the register itself when it is free
      if (m_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_beat) begin
            in_handle_q       <= s_axis_tdata[HDL_W-1:0];
            in_length_q       <= s_axis_tdata[HDL_W+LEN_W-1:HDL_W];
            pos_q             <= s_axis_tdata[HDL_W+LEN_W+POS_W-1:HDL_W+LEN_W];
            idx_q             <= rd_ptr_q;
            cnt_q             <= stored_count(wr_ptr_q, rd_ptr_q, full_q);
            res_found_q       <= 1'b0;
            res_disp_valid_q  <= 1'b0;
            res_hit_handle_q  <= '0;
            res_disp_handle_q <= '0;
            res_hit_length_q  <= '0;
            res_offset_q      <= '0;
            state_q           <= (s_axis_tuser == FUNC_ADD) ? S_ADD : S_WALK;
          end
        end
        S_ADD: begin
          // oldest handle was read on the accept beat
          res_disp_valid_q  <= full_q;
          res_disp_handle_q <= full_q ? store_rdata.handle : '0;
          wr_ptr_q          <= wr_next;
          if (full_q) begin
            rd_ptr_q <= wr_next;
          end else if (wr_next == rd_ptr_q) begin
            full_q <= 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_WALK: begin
          if (cnt_q == '0) begin
            state_q <= S_EMIT;
          end else if (walk_res.hit) begin
            res_found_q      <= 1'b1;
            res_hit_handle_q <= store_rdata.handle;
            res_hit_length_q <= store_rdata.length;
            res_offset_q     <= pos_q[LEN_W-1:0];
            state_q          <= S_EMIT;
          end else begin
            pos_q <= walk_res.rest;
            cnt_q <= cnt_q - cnt_t'(1);
            idx_q <= ptr_next(idx_q);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_tdata_q <= {res_disp_handle_q, res_offset_q, res_hit_length_q, res_hit_handle_q};
            m_tuser_q <= {res_disp_valid_q, res_found_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

[tb/sv/record_ring_offset_lookup_core_test.sv]
`timescale 1ns / 1ps
// Testbench for record_ring_offset_lookup_core: add and find beats, directed then random,
// checked against a mirror of the record ring. Depends on rrol_pkg and the core.
module record_ring_offset_lookup_core_test;
  import rrol_pkg::*;

  localparam int STALL_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int BURST_ITEMS    = 24;
  localparam int RAND_PER_PHASE = 230;
  localparam int PAD_W          = S_TDATA_W - HDL_W - LEN_W - POS_W;

  typedef struct packed {
    logic             found;
    logic [HDL_W-1:0] hit_handle;
    logic [LEN_W-1:0] hit_length;
    logic [LEN_W-1:0] offset;
    logic             disp_valid;
    logic [HDL_W-1:0] disp_handle;
  } ring_answer_t;

  // Mirror of the ring contents and pointers, plus the answers still owed by the core.
  class ring_mirror;
    logic [HDL_W-1:0] handles[DEPTH];
    logic [LEN_W-1:0] lengths[DEPTH];
    int               wr_ptr;
    int               rd_ptr;
    bit               full;
    ring_answer_t     answers_due[$];
    int               errors;
    int               shown;
    int               adds;
    int               finds;
    int               hits;
    int               displaced;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      full = 1'b0;
      errors = 0;
      shown = 0;
      adds = 0;
      finds = 0;
      hits = 0;
      displaced = 0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function int record_count();
      if (full) return DEPTH;
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return DEPTH - rd_ptr + wr_ptr;
    endfunction

    function int stored_bytes();
      int sum;
      int idx;
      sum = 0;
      idx = rd_ptr;
      for (int i = 0; i < record_count(); i++) begin
        sum += int'(lengths[idx]);
        idx = (idx + 1) % DEPTH;
      end
      return sum;
    endfunction

    function void note_item(input logic func, input logic [HDL_W-1:0] handle,
                            input logic [LEN_W-1:0] length, input logic [POS_W-1:0] position);
      ring_answer_t a;
      int           idx;
      int           n;
      int           rest;
      a = '0;
      if (func == FUNC_ADD) begin
        adds++;
        if (full) begin
          a.disp_valid  = 1'b1;
          a.disp_handle = handles[rd_ptr];
          displaced++;
        end
        handles[wr_ptr] = handle;
        lengths[wr_ptr] = length;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (full) rd_ptr = wr_ptr;
        else if (wr_ptr == rd_ptr) full = 1'b1;
      end else begin
        finds++;
        n = record_count();
        idx = rd_ptr;
        rest = int'(position);
        // walk oldest first; empty records never hold a byte
        for (int i = 0; i < n; i++) begin
          if (lengths[idx] != '0) begin
            if (rest < int'(lengths[idx])) begin
              a.found      = 1'b1;
              a.hit_handle = handles[idx];
              a.hit_length = lengths[idx];
              a.offset     = LEN_W'(rest);
              hits++;
              break;
            end
            rest -= int'(lengths[idx]);
          end
          idx = (idx + 1) % DEPTH;
        end
      end
      answers_due.push_back(a);
    endfunction

    function void check_beat(input logic [M_TDATA_W-1:0] tdata,
                             input logic [M_TUSER_W-1:0] tuser);
      ring_answer_t want;
      ring_answer_t got;
      got.found       = tuser[0];
      got.disp_valid  = tuser[1];
      got.hit_handle  = tdata[0 +: HDL_W];
      got.hit_length  = tdata[HDL_W +: LEN_W];
      got.offset      = tdata[HDL_W + LEN_W +: LEN_W];
      got.disp_handle = tdata[HDL_W + 2*LEN_W +: HDL_W];
      if (answers_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("[%0t] unexpected result beat: tdata=%h tuser=%b", $realtime, tdata, tuser);
        end
        return;
      end
      want = answers_due.pop_front();
      if (got.found !== want.found || got.hit_handle !== want.hit_handle ||
          got.hit_length !== want.hit_length || got.offset !== want.offset ||
          got.disp_valid !== want.disp_valid || got.disp_handle !== want.disp_handle) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("[%0t] mismatch exp: found=%b hit=%h len=%0d off=%0d disp=%b dh=%h",
                   $realtime, want.found, want.hit_handle, want.hit_length, want.offset,
                   want.disp_valid, want.disp_handle);
          $display("             got: found=%b hit=%h len=%0d off=%0d disp=%b dh=%h",
                   got.found, got.hit_handle, got.hit_length, got.offset,
                   got.disp_valid, got.disp_handle);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  ring_mirror mirror = new();
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  bit         hold_req = 1'b0;
  int         stall_cycles = 0;

  record_ring_offset_lookup_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one beat from the falling edge, hold it until the core takes it, then withdraw it.
  task automatic send_item(input logic func, input logic [HDL_W-1:0] handle,
                           input logic [LEN_W-1:0] length, input logic [POS_W-1:0] position);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{PAD_W{1'b0}}, position, length, handle};
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_item(func, handle, length, position);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Adds and finds in equal measure; finds mostly land inside the stored data, with boundaries and overshoots mixed in.
  task automatic send_random_item();
    int               pick;
    int               total;
    logic [LEN_W-1:0] l;
    logic [POS_W-1:0] p;
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      if (pick < 10)      l = '0;
      else if (pick < 40) l = LEN_W'($urandom_range(15, 1));
      else if (pick < 50) l = '1;
      else if (pick < 60) l = LEN_W'($urandom_range(255, 1));
      else                l = LEN_W'($urandom);
      send_item(FUNC_ADD, $urandom, l, POS_W'($urandom));
    end else begin
      total = mirror.stored_bytes();
      if (pick < 60 && total > 0)      p = POS_W'($urandom_range(total - 1));
      else if (pick < 70 && total > 0) p = POS_W'(total - 1);
      else if (pick < 80)              p = POS_W'(total);
      else if (pick < 85)              p = '0;
      else                             p = POS_W'($urandom);
      send_item(FUNC_FIND, $urandom, LEN_W'($urandom), p);
    end
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) mirror.check_beat(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, mirror.pending());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_ADD;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty ring, zero-length records, boundaries, overshoot, overwrite
    send_item(FUNC_FIND, '0, '0, '0);
    send_item(FUNC_FIND, '1, '1, '1);
    send_item(FUNC_ADD, '0, '0, '1);
    send_item(FUNC_FIND, '0, '0, '0);
    send_item(FUNC_ADD, '1, '1, '0);
    send_item(FUNC_ADD, 32'h1234_5678, 12'd1, '0);
    send_item(FUNC_FIND, '0, '0, 16'd0);
    send_item(FUNC_FIND, '0, '0, 16'd4094);
    send_item(FUNC_FIND, '0, '0, 16'd4095);
    send_item(FUNC_FIND, '0, '0, 16'd4096);
    send_item(FUNC_FIND, '0, '0, '1);
    for (int i = 0; i < 8; i++)
      send_item(FUNC_ADD, 32'ha5a5_0000 + i, (i % 3 == 0) ? '1 : LEN_W'(i % 3 - 1), '0);
    send_item(FUNC_ADD, 32'h0f0f_0f0f, 12'd9, '0);
    send_item(FUNC_FIND, '0, '0, 16'd0);
    send_item(FUNC_FIND, '0, '0, POS_W'(mirror.stored_bytes() - 1));
    send_item(FUNC_FIND, '0, '0, POS_W'(mirror.stored_bytes()));
    wait_drained();

    // hold the result side off while beats keep coming, then drain fully
    hold_req = 1'b1;
    for (int k = 0; k < BURST_ITEMS; k++) send_random_item();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 51 : 0;
      snk_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 11 : 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) send_random_item();
      wait_drained();
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DEPTH + 10) @(posedge clk_i);

    $display("run covered %0d adds (%0d overwrote the oldest record) and %0d finds (%0d hits)",
             mirror.adds, mirror.displaced, mirror.finds, mirror.hits);
    $display("mismatches: %0d, results outstanding: %0d", mirror.errors, mirror.pending());
    if (mirror.errors == 0 && mirror.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
